/* rtl/hbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_pkg: shared definitions for the HDLC bit framer
// Line constants, CRC-16/X.25 constants and the sequencer state type.
// ----------------------------------------------------------------------------
package hbf_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [2:0]  STUFF_RUN = 3'd5;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] LAST_BYTE_BIT = 5'd7;
  localparam logic [CNT_W-1:0] BYTE_END      = 5'd8;
  localparam logic [CNT_W-1:0] LAST_FCS_BIT  = 5'd15;
  localparam logic [CNT_W-1:0] FCS_END       = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG_OPEN,
    ST_DATA,
    ST_FCS,
    ST_FLAG_CLOSE
  } hbf_state_t;

endpackage

`default_nettype wire

/* rtl/hbf_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_if: channel interfaces of the HDLC bit framer
// Byte input channel and line bit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hbf_out_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic frame_start;
  logic frame_end;
  logic item_done;

  modport source (output valid, output line_bit, output frame_start,
                  output frame_end, output item_done, input ready);
  modport sink   (input valid, input line_bit, input frame_start,
                  input frame_end, input item_done, output ready);
endinterface

`default_nettype wire

/* rtl/hdlc_bit_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_bit_framer: HDLC framing with bit stuffing and CRC-16/X.25
// Serialises payload bytes LSB first between flags, stuffs a zero after five
// ones and appends the inverted reflected CRC before the closing flag.
// ----------------------------------------------------------------------------
// Channel   Port      Direction  Payload
// input     in_chan   sink       data_byte[7:0], last_byte
// result    out_chan  source     line_bit, frame_start, frame_end, item_done
//
// One line bit leaves per cycle through a single output register unless
// out_chan.ready stalls it. A new byte is taken only in idle, after the line
// bits of the previous byte (and, after a last byte, the FCS and closing flag)
// are sequenced. The CRC advances one bit per data bit in a single shared step.
// Reset is synchronous, active low, and leaves the block idle between frames.
// A low out_chan.ready holds the output register and stops the sequencer.
// ----------------------------------------------------------------------------
module hdlc_bit_framer
  import hbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  hbf_in_if.sink    in_chan,
  hbf_out_if.source out_chan
);

  hbf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [2:0]       run_r, run_nxt;
  logic             pend_r, pend_nxt;
  logic             in_frame_r, in_frame_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_bit_r, out_bit_nxt;
  logic out_start_r, out_start_nxt;
  logic out_end_r, out_end_nxt;
  logic out_done_r, out_done_nxt;

  logic        accept;
  logic        step;
  logic        stuffed;
  logic        emit_stuff;
  logic        src_bit;
  logic [2:0]  run_inc;
  logic        new_pend;
  logic        seg_end;
  logic [15:0] crc_mix;
  logic [15:0] crc_upd;

  assign accept = in_chan.valid && in_chan.ready;
  assign step   = (!out_valid_r || out_chan.ready) && (state_r != ST_IDLE);

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.line_bit    = out_bit_r;
  assign out_chan.frame_start = out_start_r;
  assign out_chan.frame_end   = out_end_r;
  assign out_chan.item_done   = out_done_r;

  // Shared bit-serial CRC step and stuffing decision.
  always_comb begin
    stuffed    = (state_r == ST_DATA) || (state_r == ST_FCS);
    emit_stuff = stuffed && pend_r;
    case (state_r)
      ST_DATA: src_bit = data_r[cnt_r[2:0]];
      ST_FCS:  src_bit = crc_r[0];
      default: src_bit = FLAG_BYTE[cnt_r[2:0]];
    endcase
    crc_mix  = crc_r ^ {15'd0, src_bit};
    crc_upd  = crc_mix[0] ? ((crc_mix >> 1) ^ CRC_POLY) : (crc_mix >> 1);
    run_inc  = run_r + 3'd1;
    new_pend = src_bit && (run_inc == STUFF_RUN);
    case (state_r)
      ST_DATA:  seg_end = emit_stuff ? (cnt_r == BYTE_END)
                                     : ((cnt_r == LAST_BYTE_BIT) && !new_pend);
      ST_FCS:   seg_end = emit_stuff ? (cnt_r == FCS_END)
                                     : ((cnt_r == LAST_FCS_BIT) && !new_pend);
      default:  seg_end = (cnt_r == LAST_BYTE_BIT);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_frame_r ? ST_DATA : ST_FLAG_OPEN;
        end
      end
      ST_FLAG_OPEN: begin
        if (step && seg_end) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (step && seg_end) begin
          state_nxt = last_r ? ST_FCS : ST_IDLE;
        end
      end
      ST_FCS: begin
        if (step && seg_end) begin
          state_nxt = ST_FLAG_CLOSE;
        end
      end
      ST_FLAG_CLOSE: begin
        if (step && seg_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    crc_nxt       = crc_r;
    run_nxt       = run_r;
    pend_nxt      = pend_r;
    in_frame_nxt  = in_frame_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_bit_nxt   = out_bit_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_done_nxt  = out_done_r;

    if (accept) begin
      data_nxt     = in_chan.data_byte;
      last_nxt     = in_chan.last_byte;
      cnt_nxt      = '0;
      in_frame_nxt = 1'b1;
      if (!in_frame_r) begin
        crc_nxt  = CRC_INIT;
        run_nxt  = '0;
        pend_nxt = 1'b0;
      end
    end

    if (step) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = emit_stuff ? 1'b0 : src_bit;
      out_start_nxt = (state_r == ST_FLAG_OPEN) && (cnt_r == '0);
      out_end_nxt   = (state_r == ST_FLAG_CLOSE) && seg_end;
      out_done_nxt  = seg_end && (((state_r == ST_DATA) && !last_r) ||
                                  (state_r == ST_FLAG_CLOSE));
      if (seg_end) begin
        cnt_nxt = '0;
      end else if (!emit_stuff) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (stuffed) begin
        if (emit_stuff) begin
          pend_nxt = 1'b0;
          run_nxt  = '0;
        end else begin
          pend_nxt = new_pend;
          run_nxt  = (src_bit && !new_pend) ? run_inc : 3'd0;
        end
      end
      case (state_r)
        ST_DATA: begin
          if (!emit_stuff) begin
            crc_nxt = ((cnt_r == LAST_BYTE_BIT) && last_r) ? ~crc_upd : crc_upd;
          end
        end
        ST_FCS: begin
          if (!emit_stuff) begin
            crc_nxt = crc_r >> 1;
          end
        end
        ST_FLAG_CLOSE: begin
          if (seg_end) begin
            crc_nxt      = CRC_INIT;
            run_nxt      = '0;
            pend_nxt     = 1'b0;
            in_frame_nxt = 1'b0;
          end
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      run_r       <= '0;
      pend_r      <= 1'b0;
      in_frame_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      in_frame_r  <= in_frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    last_r      <= last_nxt;
    out_bit_r   <= out_bit_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_done_r  <= out_done_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/hdlc_bit_framer_tb.sv */
// ----------------------------------------------------------------------------
// hdlc_bit_framer_tb: self-checking testbench for the HDLC bit framer
// Sends payload bytes in frames, predicts the framed line bits (flags, LSB
// first data, zero stuffing and the inverted CRC-16/X.25) and compares every
// line bit with the prediction, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module hdlc_bit_framer_tb;
  import hbf_pkg::*;

  localparam logic [15:0] FCS_XOR = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 110;

  typedef struct packed {
    logic line_bit;
    logic frame_start;
    logic frame_end;
    logic item_done;
  } framed_bit_t;

  logic clk;
  logic rst_n;

  hbf_in_if  in_ch ();
  hbf_out_if out_ch ();

  hdlc_bit_framer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  framed_bit_t line_q[$];
  logic [15:0] crc_acc;
  int          run_len;
  bit          frame_open;
  bit          no_idle;
  int          idle_cycles;
  int          errors;
  int          bytes_in;
  int          frames_in;
  int          bits_out;
  int          stuffed_zeros;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_bit(input logic b, input logic s, input logic e);
    line_q.push_back('{b, s, e, 1'b0});
  endfunction

  function automatic void push_flag(input bit opening);
    for (int i = 0; i < 8; i++) begin
      push_bit(FLAG_BYTE[i], opening && i == 0, !opening && i == 7);
    end
  endfunction

  // Returns the run of ones after the byte; bits are queued only when emit is set.
  function automatic int stuff_byte(input logic [7:0] b, input int run, input bit emit);
    int r;
    r = run;
    for (int i = 0; i < 8; i++) begin
      if (emit) push_bit(b[i], 1'b0, 1'b0);
      if (b[i]) begin
        r++;
        if (r >= STUFF_RUN) begin
          if (emit) begin
            push_bit(1'b0, 1'b0, 1'b0);
            stuffed_zeros++;
          end
          r = 0;
        end
      end else begin
        r = 0;
      end
    end
    return r;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    framed_bit_t tail;
    logic [15:0] fcs;
    if (!frame_open) begin
      crc_acc = CRC_INIT;
      run_len = 0;
      push_flag(1'b1);
      frame_open = 1'b1;
    end
    crc_acc = crc_byte(crc_acc, b);
    run_len = stuff_byte(b, run_len, 1'b1);
    if (last) begin
      fcs = crc_acc ^ FCS_XOR;
      run_len = stuff_byte(fcs[7:0], run_len, 1'b1);
      run_len = stuff_byte(fcs[15:8], run_len, 1'b1);
      push_flag(1'b0);
      crc_acc = CRC_INIT;
      run_len = 0;
      frame_open = 1'b0;
      frames_in++;
    end
    tail = line_q.pop_back();
    tail.item_done = 1'b1;
    line_q.push_back(tail);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    framed_bit_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.data_byte, in_ch.last_byte);
        bytes_in++;
        idle_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        bits_out++;
        if (line_q.size() == 0) begin
          report_mismatch("line bit with none expected", out_ch.line_bit, -1);
        end else begin
          want = line_q.pop_front();
          if (out_ch.line_bit !== want.line_bit)
            report_mismatch("line_bit", out_ch.line_bit, want.line_bit);
          if (out_ch.frame_start !== want.frame_start)
            report_mismatch("frame_start", out_ch.frame_start, want.frame_start);
          if (out_ch.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
          if (out_ch.item_done !== want.item_done)
            report_mismatch("item_done", out_ch.item_done, want.item_done);
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !no_idle) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = 0;
        if (!no_idle && $urandom_range(0, 99) < 15) hold = pick_gap();
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_frames();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_byte_frames();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_check_string();
    string s;
    s = "123456789";
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  task automatic test_end_stuffing();
    logic [15:0] fcs;
    int run;
    int pick;
    pick = -1;
    send_byte(8'hF8, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hF8, 1'b1);
    // Find a one-byte frame whose check sequence ends on five ones.
    for (int b = 0; b < 256; b++) begin
      fcs = crc_byte(CRC_INIT, 8'(b)) ^ FCS_XOR;
      run = stuff_byte(8'(b), 0, 1'b0);
      run = stuff_byte(fcs[7:0], run, 1'b0);
      run = stuff_byte(fcs[15:8], run, 1'b0);
      if (fcs[15] && run == 0) begin
        pick = b;
        break;
      end
    end
    if (pick >= 0) send_byte(8'(pick), 1'b1);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_byte(i[0] ? 8'hFF : 8'h1F, i == 2 || i == 5);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    int r;
    bit drained;
    logic [7:0] b;
    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 14);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        case (r)
          0: b = 8'hFF;
          1: b = 8'h7E;
          2: b = 8'hF8;
          3: b = 8'h1F;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, i == len - 1);
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_frames();
        drained = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    crc_acc         = CRC_INIT;
    run_len         = 0;
    frame_open      = 1'b0;
    no_idle         = 1'b0;
    idle_cycles     = 0;
    errors          = 0;
    bytes_in        = 0;
    frames_in       = 0;
    bits_out        = 0;
    stuffed_zeros   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_byte_frames();
    test_check_string();
    test_end_stuffing();
    test_back_to_back();
    test_random_frames();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d line bits, %0d of them stuffed zeros.",
             bytes_in, frames_in, bits_out, stuffed_zeros);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hbf_pkg.sv
rtl/hbf_if.sv
rtl/hdlc_bit_framer.sv
tb/sv/hdlc_bit_framer_tb.sv
